@@ rtl/slo_pkg.sv @@
// Shared types, constants and helpers of the stereo lo-fi effect chain.
package slo_pkg;

    localparam logic [24:0] UNITY_GAIN = 25'd16777216;
    localparam logic [17:0] PHASE_ONE  = 18'd65536;
    localparam logic [4:0]  CRUSH_FULL = 5'd16;

    typedef enum logic [2:0] {
        REG_HOLD_STEP     = 3'd0,
        REG_CRUSH_BITS    = 3'd1,
        REG_LOWPASS_ALPHA = 3'd2,
        REG_ATTACK_STEP   = 3'd3,
        REG_DECAY_STEP    = 3'd4,
        REG_SUSTAIN_LEVEL = 3'd5,
        REG_ECHO_LENGTH   = 3'd6,
        REG_ECHO_FEEDBACK = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_FRONT,
        S_LP1,
        S_LP2,
        S_LP3,
        S_LP4,
        S_GMUL,
        S_GRND,
        S_MIX,
        S_MIXR,
        S_ERD,
        S_EMUL,
        S_EWR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        G_ATTACK  = 2'd0,
        G_DECAY   = 2'd1,
        G_SUSTAIN = 2'd2
    } t_gain_stage;

    typedef struct packed {
        t_state     st;
        logic       hold_on;
        logic       latch;
        logic       crush_on;
        logic [4:0] shift;
    } t_lane_ctl;

    // Saturate a wide signed value to a Q1.15 sample.
    function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
        logic signed [15:0] r;
        begin
            if (v > 52'sd32767) begin
                r = 16'sh7fff;
            end else if (v < -52'sd32768) begin
                r = 16'sh8000;
            end else begin
                r = v[15:0];
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/stereo_lofi_effect_chain_top.sv @@
// Top level of the stereo lo-fi effect chain: registers, sequencer, lanes, merge.
// Items are taken one at a time: a new item is accepted only in the idle state, once
//   the last result has left the done state, which output stalls hold (the echo steps are skipped when off);
//   the sequencer walks the lanes' multiply steps and the echo line's read port in turn.
// Reset: synchronous, active low; a clearing pass over every address then zeroes
//   both echo lines, with no item accepted. Write configuration only while idle.
module stereo_lofi_effect_chain_top import slo_pkg::*; #(
    parameter int DELAY_DEPTH = 16384,
    parameter int MIX_AMOUNT  = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] left_in, [31:16] right_in
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] left_out, [31:16] right_out
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [17:0] DepthW   = 18'(DELAY_DEPTH);
    localparam logic [17:0] MaxLen   = 18'(DELAY_DEPTH - 1);
    localparam logic [AW-1:0] LastAddr = AW'(DELAY_DEPTH - 1);

    // configuration registers
    logic [16:0] r_hold_step;
    logic [4:0]  r_crush_bits;
    logic [15:0] r_alpha;
    logic [24:0] r_attack, r_decay, r_sustain;
    logic [13:0] r_echo_len;
    logic [15:0] r_echo_fb;

    t_state  r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_wr;
    logic [16:0]   r_phase;
    logic signed [15:0] r_in_l, r_in_r;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic        wr_en;
    t_reg_idx    reg_idx;
    logic        accept;
    logic        out_free;
    logic        hold_on;
    logic [17:0] psum;
    logic        latch;
    logic        echo_on;
    logic [17:0] len_c;
    logic [17:0] rd_diff;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    t_lane_ctl   ctl;
    logic [24:0] level;
    logic signed [15:0] g_l, g_r, m_l, m_r, e_l, e_r;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_step  <= 17'd65536;
            r_crush_bits <= CRUSH_FULL;
            r_alpha      <= 16'd65535;
            r_attack     <= UNITY_GAIN;
            r_decay      <= UNITY_GAIN;
            r_sustain    <= UNITY_GAIN;
            r_echo_len   <= 14'd1;
            r_echo_fb    <= 16'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HOLD_STEP:     r_hold_step  <= pwdata[16:0];
                REG_CRUSH_BITS:    r_crush_bits <= pwdata[4:0];
                REG_LOWPASS_ALPHA: r_alpha      <= pwdata[15:0];
                REG_ATTACK_STEP:   r_attack     <= pwdata[24:0];
                REG_DECAY_STEP:    r_decay      <= pwdata[24:0];
                REG_SUSTAIN_LEVEL: r_sustain    <= pwdata[24:0];
                REG_ECHO_LENGTH:   r_echo_len   <= pwdata[13:0];
                REG_ECHO_FEEDBACK: r_echo_fb    <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HOLD_STEP:     prdata = {15'd0, r_hold_step};
            REG_CRUSH_BITS:    prdata = {27'd0, r_crush_bits};
            REG_LOWPASS_ALPHA: prdata = {16'd0, r_alpha};
            REG_ATTACK_STEP:   prdata = {7'd0, r_attack};
            REG_DECAY_STEP:    prdata = {7'd0, r_decay};
            REG_SUSTAIN_LEVEL: prdata = {7'd0, r_sustain};
            REG_ECHO_LENGTH:   prdata = {18'd0, r_echo_len};
            REG_ECHO_FEEDBACK: prdata = {16'd0, r_echo_fb};
        endcase
    end

    // per-item decisions
    assign hold_on = (r_hold_step < 17'd65536);
    assign psum    = {1'b0, r_phase} + {1'b0, r_hold_step};
    assign latch   = hold_on && (psum >= PHASE_ONE);
    assign echo_on = (r_echo_len >= 14'd2) && (r_echo_fb != 16'd0);

    // read address trails the write address by the clamped echo length
    assign len_c   = ({4'd0, r_echo_len} > MaxLen) ? MaxLen : {4'd0, r_echo_len};
    assign rd_diff = (18'(r_wr) >= len_c) ? (18'(r_wr) - len_c)
                                          : (18'(r_wr) + DepthW - len_c);
    assign raddr   = rd_diff[AW-1:0];
    assign waddr   = (r_state == S_CLR) ? r_clr_addr : r_wr;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   n_state = (r_clr_addr == LastAddr) ? S_IDLE : S_CLR;
            S_IDLE:  n_state = accept ? S_FRONT : S_IDLE;
            S_FRONT: n_state = S_LP1;
            S_LP1:   n_state = S_LP2;
            S_LP2:   n_state = S_LP3;
            S_LP3:   n_state = S_LP4;
            S_LP4:   n_state = S_GMUL;
            S_GMUL:  n_state = S_GRND;
            S_GRND:  n_state = S_MIX;
            S_MIX:   n_state = S_MIXR;
            S_MIXR:  n_state = echo_on ? S_ERD : S_DONE;
            S_ERD:   n_state = S_EMUL;
            S_EMUL:  n_state = S_EWR;
            S_EWR:   n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready   = (r_state == S_IDLE);
        ctl.st       = r_state;
        ctl.hold_on  = hold_on;
        ctl.latch    = latch;
        ctl.crush_on = (r_crush_bits < CRUSH_FULL);
        ctl.shift    = CRUSH_FULL - r_crush_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_wr        <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // advance the hold phase once per item
            if (r_state == S_FRONT && hold_on) begin
                r_phase <= latch ? 17'(psum - PHASE_ONE) : psum[16:0];
            end
            if (r_state == S_EWR) begin
                r_wr <= (r_wr == LastAddr) ? '0 : r_wr + AW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_l <= i_s_tdata[15:0];
            r_in_r <= i_s_tdata[31:16];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data <= echo_on ? {e_r, e_l} : {m_r, m_l};
        end
    end

    slo_gain u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (r_state == S_FRONT),
        .i_attack  (r_attack),
        .i_decay   (r_decay),
        .i_sustain (r_sustain),
        .o_level   (level)
    );

    slo_lane #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_sample   (r_in_l),
        .i_alpha    (r_alpha),
        .i_level    (level),
        .i_fb       (r_echo_fb),
        .i_mix      (m_l),
        .i_raddr    (raddr),
        .i_waddr    (waddr),
        .o_gain_out (g_l),
        .o_echo_out (e_l)
    );

    slo_lane #(.DELAY_DEPTH(DELAY_DEPTH), .AW(AW)) u_lane_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_sample   (r_in_r),
        .i_alpha    (r_alpha),
        .i_level    (level),
        .i_fb       (r_echo_fb),
        .i_mix      (m_r),
        .i_raddr    (raddr),
        .i_waddr    (waddr),
        .o_gain_out (g_r),
        .o_echo_out (e_r)
    );

    slo_blend #(.MIX_AMOUNT(MIX_AMOUNT)) u_blend (
        .i_clk   (i_clk),
        .i_st    (r_state),
        .i_left  (g_l),
        .i_right (g_r),
        .o_left  (m_l),
        .o_right (m_r)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // an accepted item always starts the front stage next
    a_accept_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_FRONT))
        else $error("accepted item did not enter front stage");

    // a new result appears only out of the done state
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done state");

    // the gain envelope never leaves [0, unity]
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= UNITY_GAIN)
        else $error("gain level above unity");

    // the write index moves only on an echo write
    a_wr_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EWR) |=> $stable(r_wr))
        else $error("echo write index moved without a write");

endmodule

@@ rtl/slo_gain.sv @@
// One-shot attack/decay/sustain gain envelope shared by both lanes.
module slo_gain import slo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [24:0] i_attack,
    input  logic [24:0] i_decay,
    input  logic [24:0] i_sustain,
    output logic [24:0] o_level
);

    t_gain_stage        r_stage, n_stage;
    logic        [24:0] r_level, n_level;
    logic        [24:0] sus;
    logic        [25:0] up;
    logic signed [26:0] down;

    assign sus  = (i_sustain > UNITY_GAIN) ? UNITY_GAIN : i_sustain;
    assign up   = {1'b0, r_level} + {1'b0, i_attack};
    assign down = $signed({2'b00, r_level}) - $signed({2'b00, i_decay});

    always_comb begin
        n_stage = r_stage;
        n_level = r_level;
        unique case (r_stage)
            G_ATTACK: begin
                if (up >= {1'b0, UNITY_GAIN}) begin
                    n_level = UNITY_GAIN;
                    n_stage = G_DECAY;
                end else begin
                    n_level = up[24:0];
                end
            end
            G_DECAY: begin
                if (down <= $signed({2'b00, sus})) begin
                    n_level = sus;
                    n_stage = G_SUSTAIN;
                end else begin
                    n_level = down[24:0];
                end
            end
            default: begin
                n_level = r_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= G_ATTACK;
            r_level <= '0;
        end else if (i_adv) begin
            r_stage <= n_stage;
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

@@ rtl/slo_lane.sv @@
// One channel lane: hold latch, crusher, lowpass, gain scaling and echo line.
module slo_lane import slo_pkg::*; #(
    parameter int DELAY_DEPTH = 16384,
    parameter int AW          = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [15:0] i_sample,
    input  logic        [15:0] i_alpha,
    input  logic        [24:0] i_level,
    input  logic        [15:0] i_fb,
    input  logic signed [15:0] i_mix,
    input  logic      [AW-1:0] i_raddr,
    input  logic      [AW-1:0] i_waddr,
    output logic signed [15:0] o_gain_out,
    output logic signed [15:0] o_echo_out
);

    logic signed [15:0] mem [DELAY_DEPTH];

    logic signed [15:0] r_held;
    logic signed [31:0] r_s;
    logic signed [15:0] r_x;
    logic signed [33:0] r_diff;
    logic signed [50:0] r_prod;
    logic signed [15:0] r_y;
    logic signed [41:0] r_gprod;
    logic signed [15:0] r_g;
    logic signed [15:0] r_d;
    logic signed [32:0] r_eprod;
    logic signed [15:0] r_out;

    logic signed [15:0] xin;
    logic        [16:0] mag;
    logic        [17:0] rnd;
    logic        [17:0] rq;
    logic signed [18:0] cval;
    logic signed [15:0] crushed;
    logic signed [51:0] inc;
    logic signed [32:0] srnd;
    logic signed [42:0] grnd;
    logic signed [33:0] fbv;
    logic signed [15:0] wval;
    logic               we;

    always_comb begin
        xin = i_ctl.hold_on ? (i_ctl.latch ? i_sample : r_held) : i_sample;
        mag = xin[15] ? 17'(-$signed({xin[15], xin})) : {1'b0, xin};
        rnd = {1'b0, mag} + (18'd1 << (i_ctl.shift - 5'd1));
        rq  = (rnd >> i_ctl.shift) << i_ctl.shift;
        cval = xin[15] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
        crushed = i_ctl.crush_on ? sat16(52'(cval)) : xin;
        inc  = (52'(r_prod) + 52'sd32768) >>> 16;
        srnd = (33'(r_s) + 33'sd32768) >>> 16;
        grnd = (43'(r_gprod) + 43'sd8388608) >>> 24;
        fbv  = (34'(r_eprod) + 34'sd32768) >>> 16;
        wval = sat16(52'(i_mix) + 52'(fbv));
        we   = (i_ctl.st == S_CLR) || (i_ctl.st == S_EWR);
    end

    // hold and lowpass state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_s    <= '0;
        end else begin
            if (i_ctl.st == S_FRONT && i_ctl.latch) begin
                r_held <= i_sample;
            end
            if (i_ctl.st == S_LP3) begin
                r_s <= r_s + inc[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.st)
            S_FRONT: r_x     <= crushed;
            S_LP1:   r_diff  <= $signed({{2{r_x[15]}}, r_x, 16'd0}) - 34'(r_s);
            S_LP2:   r_prod  <= r_diff * $signed({1'b0, i_alpha});
            S_LP4:   r_y     <= sat16(52'(srnd));
            S_GMUL:  r_gprod <= r_y * $signed({1'b0, i_level});
            S_GRND:  r_g     <= sat16(52'(grnd));
            S_EMUL:  r_eprod <= r_d * $signed({1'b0, i_fb});
            S_EWR:   r_out   <= sat16(52'(i_mix) + 52'(r_d));
            default: r_x     <= r_x;
        endcase
    end

    // echo line: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[i_waddr] <= (i_ctl.st == S_CLR) ? 16'sd0 : wval;
        end
        if (i_ctl.st == S_ERD) begin
            r_d <= mem[i_raddr];
        end
    end

    assign o_gain_out = r_g;
    assign o_echo_out = r_out;

endmodule

@@ rtl/slo_blend.sv @@
// Merge stage: blends each lane toward the mono mix by MIX_AMOUNT out of 256.
module slo_blend import slo_pkg::*; #(
    parameter int MIX_AMOUNT = 0
) (
    input  logic               i_clk,
    input  t_state             i_st,
    input  logic signed [15:0] i_left,
    input  logic signed [15:0] i_right,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_right
);

    localparam int MixQ = (MIX_AMOUNT > 256) ? 256 : MIX_AMOUNT;
    localparam logic signed [26:0] KeepK = 27'(2 * (256 - MixQ));
    localparam logic signed [26:0] MixK  = 27'(MixQ);

    logic signed [26:0] r_num_l, r_num_r;
    logic signed [15:0] r_l, r_r;
    logic signed [26:0] sum_lr;
    logic signed [26:0] rl, rr;

    assign sum_lr = 27'(i_left) + 27'(i_right);
    assign rl = (r_num_l + 27'sd256) >>> 9;
    assign rr = (r_num_r + 27'sd256) >>> 9;

    always_ff @(posedge i_clk) begin
        if (i_st == S_MIX) begin
            r_num_l <= 27'(i_left) * KeepK + sum_lr * MixK;
            r_num_r <= 27'(i_right) * KeepK + sum_lr * MixK;
        end
        if (i_st == S_MIXR) begin
            if (MixQ == 0) begin
                r_l <= i_left;
                r_r <= i_right;
            end else begin
                r_l <= sat16(52'(rl));
                r_r <= sat16(52'(rr));
            end
        end
    end

    assign o_left  = r_l;
    assign o_right = r_r;

endmodule
